### sv/rcc_pkg.sv
// Shared types, constants and helper functions of the grid raycast column core.
package rcc_pkg;

  localparam int MAP_SIDE   = 8;
  localparam int CELL_SHIFT = 6;
  localparam int ANGLE_BITS = 12;
  localparam int FRAC_BITS  = 8;

  localparam int CELL_FX  = CELL_SHIFT + FRAC_BITS;
  localparam int POS_W    = 9 + FRAC_BITS;
  localparam int MAG_W    = CELL_FX + 1;
  localparam int TRIG_W   = 18;
  localparam int ABS_W    = TRIG_W - 1;
  localparam int RU_W     = 21;
  localparam int RV_W     = 40;
  localparam int DIV_NW   = 32;
  localparam int DIV_DW   = 18;
  localparam int D2_W     = 36;
  localparam int RT_W     = 18;
  localparam int DIST_W   = 19;
  localparam int CORDIC_N = 16;
  localparam int Q_DEPTH  = 2;
  localparam int QP_W     = $clog2(Q_DEPTH);

  localparam logic signed [TRIG_W-1:0] Q16_ONE = 18'sd65536;
  localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;

  typedef enum logic [7:0] {
    CFG_MAP_CELLS     = 8'd0,
    CFG_SCREEN_HEIGHT = 8'd1,
    CFG_MAX_STEPS     = 8'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [11:0] ray_angle;
    logic [11:0] view_angle;
  } in_item_t;

  typedef struct packed {
    logic        hit_found;
    logic        hit_side;
    logic [16:0] hit_x;
    logic [16:0] hit_y;
    logic [17:0] distance;
    logic [9:0]  wall_height;
    logic [8:0]  wall_top;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]      px;
    logic [POS_W-1:0]      py;
    logic                  h_en;
    logic                  h_neg;
    logic [RU_W-1:0]       h_ru;
    logic [RV_W-1:0]       h_rv;
    logic [RV_W-1:0]       h_sv;
    logic                  v_en;
    logic                  v_neg;
    logic [RU_W-1:0]       v_ru;
    logic [RV_W-1:0]       v_rv;
    logic [RV_W-1:0]       v_sv;
    logic [ANGLE_BITS-1:0] adiff;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Arctangent per CORDIC iteration, 2^16 units per turn.
  function automatic logic [13:0] atan_turn16(logic [3:0] i);
    case (i)
      4'd0:    return 14'd8192;
      4'd1:    return 14'd4836;
      4'd2:    return 14'd2555;
      4'd3:    return 14'd1297;
      4'd4:    return 14'd651;
      4'd5:    return 14'd326;
      4'd6:    return 14'd163;
      4'd7:    return 14'd81;
      4'd8:    return 14'd41;
      4'd9:    return 14'd20;
      4'd10:   return 14'd10;
      4'd11:   return 14'd5;
      4'd12:   return 14'd3;
      4'd13:   return 14'd1;
      4'd14:   return 14'd1;
      default: return 14'd0;
    endcase
  endfunction

  // Shift right, rounding toward zero.
  function automatic logic signed [19:0] shr_tz(logic signed [19:0] v, logic [3:0] s);
    logic signed [19:0] m;
    m = -v;
    if (v < 0) return -(m >>> s);
    return v >>> s;
  endfunction

  function automatic logic is_wall(logic [63:0] cells, logic signed [RV_W-1:0] x,
                                   logic signed [RV_W-1:0] y);
    logic signed [RV_W-1:0] mx;
    logic signed [RV_W-1:0] my;
    logic [5:0] idx;
    mx = x >>> CELL_FX;
    my = y >>> CELL_FX;
    idx = 6'(my * MAP_SIDE + mx);
    if (x[RV_W-1] || y[RV_W-1]) return 1'b0;
    if (mx >= MAP_SIDE || my >= MAP_SIDE) return 1'b0;
    return cells[idx];
  endfunction

endpackage

### sv/grid_raycast_column_core.sv
// The front end runs four divisions per ray on its one shared divider and takes a new ray
// only once the last one has been pushed; the back end then steps its two passes.
// A two-entry job queue lets the front end set up the next ray while the back end steps.
// Reset: synchronous, active low; registers return to their defaults, the queue empties,
// no clearing pass.
module grid_raycast_column_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rcc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] map_cells_r;
  logic [9:0]  screen_height_r;
  logic [3:0]  max_steps_r;

  logic             q_push, q_pop;
  rcc_pkg::job_t    q_in, q_head;
  rcc_pkg::q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_cells_r     <= 64'd0;
      screen_height_r <= 10'd512;
      max_steps_r     <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcc_pkg::CFG_MAP_CELLS:     map_cells_r     <= cfg_data;
        rcc_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data[9:0];
        rcc_pkg::CFG_MAX_STEPS:     max_steps_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  rcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (q_push),
    .push_data (q_in),
    .q_stat    (q_stat)
  );

  rcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  rcc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .q_stat        (q_stat),
    .pop           (q_pop),
    .map_cells     (map_cells_r),
    .screen_height (screen_height_r),
    .max_steps     (max_steps_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("job queue popped while empty");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front end took a transaction without going busy");

endmodule

### sv/rcc_cordic.sv
// Iterative 16-step CORDIC giving Q1.16 cosine and sine of a 16-bit angle.
module rcc_cordic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [15:0]                          angle,
  output logic                                 done,
  output logic signed [rcc_pkg::TRIG_W-1:0]    co,
  output logic signed [rcc_pkg::TRIG_W-1:0]    si
);

  logic               busy_r;
  logic               done_r;
  logic [3:0]         i_r;
  logic signed [19:0] x_r, y_r;
  logic signed [17:0] z_r;
  logic [1:0]         quad_r;
  logic               rzero_r;

  logic signed [19:0] dx, dy, x_nxt, y_nxt;
  logic signed [17:0] at, z_nxt;
  logic signed [rcc_pkg::TRIG_W-1:0] xc, yc;

  always_comb begin
    dx = rcc_pkg::shr_tz(x_r, i_r);
    dy = rcc_pkg::shr_tz(y_r, i_r);
    at = signed'({4'b0, rcc_pkg::atan_turn16(i_r)});
    if (!z_r[17]) begin
      x_nxt = x_r - dy;
      y_nxt = y_r + dx;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dy;
      y_nxt = y_r - dx;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        i_r     <= '0;
        x_r     <= rcc_pkg::CORDIC_GAIN;
        y_r     <= '0;
        z_r     <= signed'({4'b0, angle[13:0]});
        quad_r  <= angle[15:14];
        rzero_r <= (angle[13:0] == 14'd0);
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        i_r <= i_r + 4'd1;
        if (i_r == 4'(rcc_pkg::CORDIC_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // clamp to +-1.0; zero angle within a quadrant is exact
  always_comb begin
    if (rzero_r) xc = rcc_pkg::Q16_ONE;
    else if (x_r > 20'sd65536) xc = rcc_pkg::Q16_ONE;
    else if (x_r < -20'sd65536) xc = -rcc_pkg::Q16_ONE;
    else xc = rcc_pkg::TRIG_W'(x_r);
    if (rzero_r) yc = '0;
    else if (y_r > 20'sd65536) yc = rcc_pkg::Q16_ONE;
    else if (y_r < -20'sd65536) yc = -rcc_pkg::Q16_ONE;
    else yc = rcc_pkg::TRIG_W'(y_r);
    case (quad_r)
      2'd0: begin co = xc;  si = yc;  end
      2'd1: begin co = -yc; si = xc;  end
      2'd2: begin co = -xc; si = -yc; end
      default: begin co = yc; si = -xc; end
    endcase
  end

  assign done = done_r;

endmodule

### sv/rcc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rcc_div #(
  parameter int NUM_W = rcc_pkg::DIV_NW,
  parameter int DEN_W = rcc_pkg::DIV_DW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [NUM_W-1:0] quo_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W-1:0] rem_nxt;
  logic             q_bit;

  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    q_bit = (trial >= {1'b0, den_r});
    rem_nxt = q_bit ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[NUM_W-2:0], q_bit};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### sv/rcc_queue.sv
// Short job queue between the ray setup front end and the stepping back end.
module rcc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rcc_pkg::job_t     push_data,
  input  logic              pop,
  output rcc_pkg::job_t     head,
  output rcc_pkg::q_stat_t  stat
);

  // depth is a power of two so the pointers wrap on their own
  rcc_pkg::job_t                mem_r [rcc_pkg::Q_DEPTH];
  logic [rcc_pkg::QP_W-1:0]     wr_r, rd_r;
  logic [rcc_pkg::QP_W:0]       cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + rcc_pkg::QP_W'(1);
      if (pop)  rd_r <= rd_r + rcc_pkg::QP_W'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (rcc_pkg::QP_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (rcc_pkg::QP_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign head       = mem_r[rd_r];
  assign stat.full  = (cnt_r == (rcc_pkg::QP_W+1)'(rcc_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

### sv/rcc_front.sv
// Front end: accepts a ray, takes its sine and cosine and sets up both gridline passes.
module rcc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rcc_pkg::in_item_t in_data,
  output logic              push,
  output rcc_pkg::job_t     push_data,
  input  rcc_pkg::q_stat_t  q_stat
);

  localparam int PW = rcc_pkg::POS_W;
  localparam int FX = rcc_pkg::CELL_FX;
  localparam logic [11:0] HALF    = 12'(1 << (rcc_pkg::ANGLE_BITS - 1));
  localparam logic [11:0] QUARTER = 12'(1 << (rcc_pkg::ANGLE_BITS - 2));
  localparam logic [rcc_pkg::MAG_W-1:0] CELL_MAG = rcc_pkg::MAG_W'(1 << FX);

  typedef enum logic [2:0] {F_IDLE, F_COR, F_SETUP, F_MUL, F_DIV, F_WAIT, F_PUSH} fstate_t;
  typedef enum logic [1:0] {DS_H_OFF, DS_H_STEP, DS_V_OFF, DS_V_STEP} div_slot_t;

  fstate_t   state_r;
  div_slot_t slot_r;

  logic [PW-1:0]                    px_r, py_r;
  logic [11:0]                      ra_r, va_r;
  logic [rcc_pkg::MAG_W-1:0]        mag_h_r, mag_v_r;
  logic [rcc_pkg::ABS_W-1:0]        abs_co_r, abs_si_r;
  logic                             co_neg_r, si_neg_r;
  logic [rcc_pkg::DIV_NW-1:0]       dnum_r;
  logic [rcc_pkg::DIV_DW-1:0]       dden_r;
  rcc_pkg::job_t                    job_r;

  logic                             accept;
  logic                             cor_done, div_done;
  logic signed [rcc_pkg::TRIG_W-1:0] co, si, abs_co, abs_si;
  logic [rcc_pkg::DIV_NW-1:0]       quo;
  logic [rcc_pkg::RV_W-1:0]         sq;
  logic [rcc_pkg::MAG_W-1:0]        mul_a;
  logic [rcc_pkg::ABS_W-1:0]        mul_b;
  logic                             q_neg;

  assign accept   = in_valid && (state_r == F_IDLE);
  assign in_stall = (state_r != F_IDLE);
  assign push     = (state_r == F_PUSH) && !q_stat.full;
  assign push_data = job_r;

  rcc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .angle (16'(in_data.ray_angle) << (16 - rcc_pkg::ANGLE_BITS)),
    .done  (cor_done),
    .co    (co),
    .si    (si)
  );

  rcc_div #(.NUM_W(rcc_pkg::DIV_NW), .DEN_W(rcc_pkg::DIV_DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == F_DIV),
    .num   (dnum_r),
    .den   (dden_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    abs_co = co[rcc_pkg::TRIG_W-1] ? -co : co;
    abs_si = si[rcc_pkg::TRIG_W-1] ? -si : si;
    case (slot_r)
      DS_H_OFF:  begin mul_a = mag_h_r;  mul_b = abs_co_r; end
      DS_H_STEP: begin mul_a = CELL_MAG; mul_b = abs_co_r; end
      DS_V_OFF:  begin mul_a = mag_v_r;  mul_b = abs_si_r; end
      default:   begin mul_a = CELL_MAG; mul_b = abs_si_r; end
    endcase
    q_neg = (slot_r == DS_H_OFF || slot_r == DS_H_STEP) ? co_neg_r : si_neg_r;
    sq = q_neg ? -rcc_pkg::RV_W'(quo) : rcc_pkg::RV_W'(quo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      slot_r  <= DS_H_OFF;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            px_r    <= PW'(in_data.pos_x) << rcc_pkg::FRAC_BITS;
            py_r    <= PW'(in_data.pos_y) << rcc_pkg::FRAC_BITS;
            ra_r    <= in_data.ray_angle;
            va_r    <= in_data.view_angle;
            state_r <= F_COR;
          end
        end
        F_COR: begin
          if (cor_done) state_r <= F_SETUP;
        end
        F_SETUP: begin
          abs_co_r <= abs_co[rcc_pkg::ABS_W-1:0];
          abs_si_r <= abs_si[rcc_pkg::ABS_W-1:0];
          co_neg_r <= co[rcc_pkg::TRIG_W-1];
          si_neg_r <= si[rcc_pkg::TRIG_W-1];
          job_r.px    <= px_r;
          job_r.py    <= py_r;
          job_r.adiff <= va_r - ra_r;
          job_r.h_en  <= (ra_r != 12'd0) && (ra_r != HALF) && (si != '0);
          job_r.h_neg <= (ra_r > HALF);
          job_r.v_en  <= (ra_r != QUARTER) && (ra_r != 12'(3 * QUARTER)) && (co != '0);
          job_r.v_neg <= (ra_r > QUARTER) && (ra_r < 12'(3 * QUARTER));
          // first crossing: one LSB below the line when moving toward lower values
          if (ra_r > HALF) begin
            job_r.h_ru <= rcc_pkg::RU_W'({py_r[PW-1:FX], {FX{1'b0}}}) - rcc_pkg::RU_W'(1);
            mag_h_r    <= rcc_pkg::MAG_W'(py_r[FX-1:0]) + rcc_pkg::MAG_W'(1);
          end else begin
            job_r.h_ru <= rcc_pkg::RU_W'({py_r[PW-1:FX], {FX{1'b0}}}) +
                          (rcc_pkg::RU_W'(1) << FX);
            mag_h_r    <= CELL_MAG - rcc_pkg::MAG_W'(py_r[FX-1:0]);
          end
          if ((ra_r > QUARTER) && (ra_r < 12'(3 * QUARTER))) begin
            job_r.v_ru <= rcc_pkg::RU_W'({px_r[PW-1:FX], {FX{1'b0}}}) - rcc_pkg::RU_W'(1);
            mag_v_r    <= rcc_pkg::MAG_W'(px_r[FX-1:0]) + rcc_pkg::MAG_W'(1);
          end else begin
            job_r.v_ru <= rcc_pkg::RU_W'({px_r[PW-1:FX], {FX{1'b0}}}) +
                          (rcc_pkg::RU_W'(1) << FX);
            mag_v_r    <= CELL_MAG - rcc_pkg::MAG_W'(px_r[FX-1:0]);
          end
          slot_r  <= DS_H_OFF;
          state_r <= F_MUL;
        end
        F_MUL: begin
          dnum_r  <= rcc_pkg::DIV_NW'(mul_a) * rcc_pkg::DIV_NW'(mul_b);
          dden_r  <= (slot_r == DS_H_OFF || slot_r == DS_H_STEP) ?
                     rcc_pkg::DIV_DW'(abs_si_r) : rcc_pkg::DIV_DW'(abs_co_r);
          state_r <= F_DIV;
        end
        F_DIV: begin
          state_r <= F_WAIT;
        end
        F_WAIT: begin
          if (div_done) begin
            case (slot_r)
              DS_H_OFF:  job_r.h_rv <= rcc_pkg::RV_W'(px_r) + sq;
              DS_H_STEP: job_r.h_sv <= sq;
              DS_V_OFF:  job_r.v_rv <= rcc_pkg::RV_W'(py_r) + sq;
              default:   job_r.v_sv <= sq;
            endcase
            if (slot_r == DS_V_STEP) begin
              state_r <= F_PUSH;
            end else begin
              slot_r  <= div_slot_t'(slot_r + 2'd1);
              state_r <= F_MUL;
            end
          end
        end
        F_PUSH: begin
          if (!q_stat.full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/rcc_back.sv
// Back end: steps both gridline passes, picks the nearer hit and derives distance and height.
module rcc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rcc_pkg::job_t       head,
  input  rcc_pkg::q_stat_t    q_stat,
  output logic                pop,
  input  logic [63:0]         map_cells,
  input  logic [9:0]          screen_height,
  input  logic [3:0]          max_steps,
  output logic                out_valid,
  input  logic                out_stall,
  output rcc_pkg::out_item_t  out_data
);

  localparam int RUW = rcc_pkg::RU_W;
  localparam int RVW = rcc_pkg::RV_W;
  localparam logic signed [RUW-1:0] CELL_ONE = RUW'(1 << rcc_pkg::CELL_FX);
  localparam int SQRT_N = rcc_pkg::D2_W / 2;

  typedef enum logic [3:0] {
    B_IDLE, B_HPASS, B_VPASS, B_SQ, B_SEL, B_COR, B_SQRT, B_MUL, B_HGT, B_DIV, B_OUT
  } bstate_t;

  bstate_t state_r;

  rcc_pkg::job_t            job_r;
  logic signed [RUW-1:0]    ru_r;
  logic signed [RVW-1:0]    rv_r;
  logic [3:0]               k_r;
  logic                     hh_r, vh_r, side_r;
  logic [16:0]              hx_r, hy_r, vx_r, vy_r, fx_r, fy_r;
  logic [1:0]               sq_r;
  logic [rcc_pkg::D2_W-1:0] dh_r, dv_r, v_r, res_r, bit_r;
  logic [4:0]               sqn_r;
  logic [rcc_pkg::DIST_W-1:0] dist_r;
  logic [9:0]               height_r;
  logic                     out_valid_r;
  rcc_pkg::out_item_t       out_r;

  logic signed [RVW-1:0]    hx, hy, vx, vy;
  logic                     h_wall, v_wall;
  logic signed [17:0]       diff;
  logic signed [35:0]       sqv;
  logic [rcc_pkg::D2_W-1:0] sum;
  logic                     cor_done, div_done;
  logic signed [rcc_pkg::TRIG_W-1:0] cc, cs_unused;
  logic [rcc_pkg::DIV_NW-1:0] quo;
  logic [34:0]              prod;
  logic                     out_free;
  logic                     found;

  assign pop       = (state_r == B_IDLE) && !q_stat.empty;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign found     = hh_r || vh_r;

  rcc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == B_SEL) && found),
    .angle (16'(job_r.adiff) << (16 - rcc_pkg::ANGLE_BITS)),
    .done  (cor_done),
    .co    (cc),
    .si    (cs_unused)
  );

  rcc_div #(.NUM_W(rcc_pkg::DIV_NW), .DEN_W(rcc_pkg::DIV_DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == B_HGT) && (dist_r != '0)),
    .num   (rcc_pkg::DIV_NW'(screen_height) << rcc_pkg::CELL_FX),
    .den   (dist_r[rcc_pkg::DIV_DW-1:0]),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    hx = rv_r;
    hy = RVW'(ru_r);
    vx = RVW'(ru_r);
    vy = rv_r;
    h_wall = rcc_pkg::is_wall(map_cells, hx, hy);
    v_wall = rcc_pkg::is_wall(map_cells, vx, vy);
    case (sq_r)
      2'd0:    diff = signed'({1'b0, hx_r}) - signed'({1'b0, job_r.px});
      2'd1:    diff = signed'({1'b0, hy_r}) - signed'({1'b0, job_r.py});
      2'd2:    diff = signed'({1'b0, vx_r}) - signed'({1'b0, job_r.px});
      default: diff = signed'({1'b0, vy_r}) - signed'({1'b0, job_r.py});
    endcase
    sqv  = diff * diff;
    sum  = res_r + bit_r;
    prod = res_r[rcc_pkg::RT_W-1:0] * cc[rcc_pkg::ABS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // B_OUT sets valid itself when the output register frees up
      if (out_valid_r && !out_stall && state_r != B_OUT) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_stat.empty) begin
            job_r   <= head;
            ru_r    <= $signed(head.h_ru);
            rv_r    <= $signed(head.h_rv);
            k_r     <= '0;
            hh_r    <= 1'b0;
            vh_r    <= 1'b0;
            state_r <= B_HPASS;
          end
        end
        B_HPASS: begin
          if (!job_r.h_en || k_r == max_steps || h_wall) begin
            if (job_r.h_en && k_r != max_steps) begin
              hh_r <= 1'b1;
              hx_r <= hx[16:0];
              hy_r <= hy[16:0];
            end
            ru_r    <= $signed(job_r.v_ru);
            rv_r    <= $signed(job_r.v_rv);
            k_r     <= '0;
            state_r <= B_VPASS;
          end else begin
            ru_r <= ru_r + (job_r.h_neg ? -CELL_ONE : CELL_ONE);
            rv_r <= rv_r + $signed(job_r.h_sv);
            k_r  <= k_r + 4'd1;
          end
        end
        B_VPASS: begin
          if (!job_r.v_en || k_r == max_steps || v_wall) begin
            if (job_r.v_en && k_r != max_steps) begin
              vh_r <= 1'b1;
              vx_r <= vx[16:0];
              vy_r <= vy[16:0];
            end
            sq_r    <= 2'd0;
            state_r <= B_SQ;
          end else begin
            ru_r <= ru_r + (job_r.v_neg ? -CELL_ONE : CELL_ONE);
            rv_r <= rv_r + $signed(job_r.v_sv);
            k_r  <= k_r + 4'd1;
          end
        end
        B_SQ: begin
          case (sq_r)
            2'd0:    dh_r <= rcc_pkg::D2_W'(sqv);
            2'd1:    dh_r <= dh_r + rcc_pkg::D2_W'(sqv);
            2'd2:    dv_r <= rcc_pkg::D2_W'(sqv);
            default: dv_r <= dv_r + rcc_pkg::D2_W'(sqv);
          endcase
          sq_r <= sq_r + 2'd1;
          if (sq_r == 2'd3) state_r <= B_SEL;
        end
        B_SEL: begin
          res_r <= '0;
          bit_r <= rcc_pkg::D2_W'(1) << (rcc_pkg::D2_W - 2);
          sqn_r <= '0;
          if (!found) begin
            side_r   <= 1'b0;
            fx_r     <= '0;
            fy_r     <= '0;
            dist_r   <= '0;
            height_r <= '0;
            state_r  <= B_OUT;
          end else begin
            // ties go to the horizontal hit
            if (vh_r && (!hh_r || dv_r < dh_r)) begin
              side_r <= 1'b1;
              fx_r   <= vx_r;
              fy_r   <= vy_r;
              v_r    <= dv_r;
            end else begin
              side_r <= 1'b0;
              fx_r   <= hx_r;
              fy_r   <= hy_r;
              v_r    <= dh_r;
            end
            state_r <= B_COR;
          end
        end
        B_COR: begin
          if (cor_done) state_r <= B_SQRT;
        end
        B_SQRT: begin
          if (v_r >= sum) begin
            v_r   <= v_r - sum;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          sqn_r <= sqn_r + 5'd1;
          if (sqn_r == 5'(SQRT_N - 1)) state_r <= B_MUL;
        end
        B_MUL: begin
          // ray behind the viewer gives zero distance
          dist_r  <= (cc > 0) ? prod[34:16] : '0;
          state_r <= B_HGT;
        end
        B_HGT: begin
          if (dist_r == '0) begin
            height_r <= screen_height;
            state_r  <= B_OUT;
          end else begin
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          if (div_done) begin
            height_r <= (quo > rcc_pkg::DIV_NW'(screen_height)) ? screen_height : quo[9:0];
            state_r  <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_r.hit_found   <= found;
            out_r.hit_side    <= side_r;
            out_r.hit_x       <= fx_r;
            out_r.hit_y       <= fy_r;
            out_r.distance    <= (dist_r > rcc_pkg::DIST_W'(18'h3FFFF)) ? 18'h3FFFF
                                                                          : dist_r[17:0];
            out_r.wall_height <= height_r;
            out_r.wall_top    <= 9'((screen_height >> 1) - (height_r >> 1));
            out_valid_r       <= 1'b1;
            state_r           <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

### bench/tb_grid_raycast_column_core.sv
// Self-checking testbench for the grid raycast column core with a ray-casting scoreboard.
`timescale 1ns / 100ps

module tb_grid_raycast_column_core;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 400;

  class ray_scoreboard;
    rcc_pkg::out_item_t column_q[$];
    logic [63:0] walls;
    int unsigned scr_h;
    int unsigned step_max;
    int errors;
    longint atan_tab[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3,
                             1, 1, 0};

    function new();
      walls = 64'd0;
      scr_h = 512;
      step_max = 8;
      errors = 0;
    endfunction

    function void set_reg(rcc_pkg::cfg_idx_t idx, logic [63:0] val);
      case (idx)
        rcc_pkg::CFG_MAP_CELLS: walls = val;
        rcc_pkg::CFG_SCREEN_HEIGHT: scr_h = int'(val[9:0]);
        rcc_pkg::CFG_MAX_STEPS: step_max = int'(val[3:0]);
        default: ;
      endcase
    endfunction

    // a: angle in 2^16 units per turn
    function void trig(int unsigned a, output longint co, output longint si);
      longint x, y, z, dx, dy;
      int unsigned quad;
      quad = (a >> 14) & 3;
      z = a & 16'h3FFF;
      x = 65536;
      y = 0;
      if (z != 0) begin
        x = 39797;
        for (int i = 0; i < 16; i++) begin
          dx = x / (64'sd1 << i);
          dy = y / (64'sd1 << i);
          if (z >= 0) begin
            x -= dy; y += dx; z -= atan_tab[i];
          end else begin
            x += dy; y -= dx; z += atan_tab[i];
          end
        end
        if (x > 65536) x = 65536;
        if (x < -65536) x = -65536;
        if (y > 65536) y = 65536;
        if (y < -65536) y = -65536;
      end
      case (quad)
        0: begin co = x; si = y; end
        1: begin co = -y; si = x; end
        2: begin co = -x; si = -y; end
        default: begin co = y; si = -x; end
      endcase
    endfunction

    function longint crossing(longint mag, longint num, longint den);
      longint unsigned n, p;
      n = (num < 0) ? -num : num;
      p = (longint'(mag) * n) / den;
      return (num < 0) ? -longint'(p) : longint'(p);
    endfunction

    function bit wall_at(longint x, longint y);
      longint mx, my;
      if (x < 0 || y < 0) return 0;
      mx = x >>> rcc_pkg::CELL_FX;
      my = y >>> rcc_pkg::CELL_FX;
      if (mx >= rcc_pkg::MAP_SIDE || my >= rcc_pkg::MAP_SIDE) return 0;
      return walls[my * rcc_pkg::MAP_SIDE + mx];
    endfunction

    // u steps by whole cells; swap means u is y
    function bit trace(longint pu, longint pv, bit neg, longint num, longint den, bit swap,
                       output longint hx, output longint hy);
      longint cell_idx, ru, su, rv, sv, mag, x, y;
      cell_idx = pu >>> rcc_pkg::CELL_FX;
      hx = 0;
      hy = 0;
      if (neg) begin
        ru = (cell_idx << rcc_pkg::CELL_FX) - 1;
        su = -(64'sd1 << rcc_pkg::CELL_FX);
        mag = pu - ru;
      end else begin
        ru = (cell_idx + 1) << rcc_pkg::CELL_FX;
        su = 64'sd1 << rcc_pkg::CELL_FX;
        mag = ru - pu;
      end
      rv = pv + crossing(mag, num, den);
      sv = crossing(64'sd1 << rcc_pkg::CELL_FX, num, den);
      for (int unsigned k = 0; k < step_max; k++) begin
        x = swap ? rv : ru;
        y = swap ? ru : rv;
        if (wall_at(x, y)) begin
          hx = x; hy = y;
          return 1;
        end
        ru += su;
        rv += sv;
      end
      return 0;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b; res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    function void note_ray(rcc_pkg::in_item_t it);
      longint px, py, co, si, cc, cs, hx, hy, vx, vy, fx, fy;
      int unsigned ra, va;
      bit hh, vh, side;
      longint unsigned dh, dv, d2, corr_dist, height;
      rcc_pkg::out_item_t r;
      px = longint'(it.pos_x) << rcc_pkg::FRAC_BITS;
      py = longint'(it.pos_y) << rcc_pkg::FRAC_BITS;
      ra = int'(it.ray_angle);
      va = int'(it.view_angle);
      hh = 0; vh = 0; side = 0; corr_dist = 0; height = 0; fx = 0; fy = 0;
      trig(ra << 4, co, si);
      if (ra != 0 && ra != 2048 && si != 0)
        hh = trace(py, px, ra > 2048, co, (si < 0) ? -si : si, 1, hx, hy);
      if (ra != 1024 && ra != 3072 && co != 0)
        vh = trace(px, py, ra > 1024 && ra < 3072, si, (co < 0) ? -co : co, 0, vx, vy);
      if (hh || vh) begin
        dh = 0; dv = 0;
        if (hh) dh = (hx - px) * (hx - px) + (hy - py) * (hy - py);
        if (vh) dv = (vx - px) * (vx - px) + (vy - py) * (vy - py);
        if (vh && (!hh || dv < dh)) begin
          fx = vx; fy = vy; d2 = dv; side = 1;
        end else begin
          fx = hx; fy = hy; d2 = dh;
        end
        trig(((va - ra) & 12'hFFF) << 4, cc, cs);
        corr_dist = (cc > 0) ? (root(d2) * longint'(cc)) >> 16 : 0;
        height = (corr_dist == 0) ? scr_h
                                  : ((longint'(scr_h) << rcc_pkg::CELL_FX) / corr_dist);
        if (height > scr_h) height = scr_h;
      end
      r.hit_found = hh || vh;
      r.hit_side = side;
      r.hit_x = (fx < 0) ? 17'd0 : (fx > 17'h1FFFF) ? 17'h1FFFF : fx[16:0];
      r.hit_y = (fy < 0) ? 17'd0 : (fy > 17'h1FFFF) ? 17'h1FFFF : fy[16:0];
      r.distance = (corr_dist > 18'h3FFFF) ? 18'h3FFFF : corr_dist[17:0];
      r.wall_height = height[9:0];
      r.wall_top = 9'((scr_h >> 1) - (height >> 1));
      column_q.push_back(r);
    endfunction

    function void check_column(rcc_pkg::out_item_t got);
      rcc_pkg::out_item_t want;
      if (column_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected column result %p", got);
        return;
      end
      want = column_q.pop_front();
      if (got.hit_found !== want.hit_found || got.hit_side !== want.hit_side ||
          got.hit_x !== want.hit_x || got.hit_y !== want.hit_y ||
          got.distance !== want.distance || got.wall_height !== want.wall_height ||
          got.wall_top !== want.wall_top) begin
        errors++;
        if (errors <= 10) $display("column mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  rcc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  rcc_pkg::out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] cfg_index = 0;
  logic [63:0] cfg_data = 0;

  ray_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int cycles = 0;
  int ph_idle[4] = '{0, 74, 0, 38};
  int ph_stall[4] = '{0, 0, 74, 38};

  grid_raycast_column_core dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) hold_left--;
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_column(out_data);

  task automatic send_ray(rcc_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_ray(it);
  endtask

  // valid stays up between back-to-back writes; configure drops it after the last one
  task automatic write_reg(rcc_pkg::cfg_idx_t idx, logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.column_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] m, logic [9:0] h, logic [3:0] s);
    write_reg(rcc_pkg::CFG_MAP_CELLS, m);
    write_reg(rcc_pkg::CFG_SCREEN_HEIGHT, {54'd0, h});
    write_reg(rcc_pkg::CFG_MAX_STEPS, {60'd0, s});
    cfg_valid <= 0;
  endtask

  function automatic rcc_pkg::in_item_t ray(int x, int y, int a, int v);
    rcc_pkg::in_item_t it;
    it.pos_x = 9'(x); it.pos_y = 9'(y); it.ray_angle = 12'(a); it.view_angle = 12'(v);
    return it;
  endfunction

  function automatic rcc_pkg::in_item_t random_ray();
    rcc_pkg::in_item_t it;
    it.pos_x = 9'($urandom_range(511));
    it.pos_y = 9'($urandom_range(511));
    it.ray_angle = 12'($urandom_range(4095));
    if ($urandom_range(3) == 0) it.view_angle = 12'($urandom_range(4095));
    else it.view_angle = 12'(int'(it.ray_angle) + int'($urandom_range(700)) - 350);
    return it;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // border walls only
    configure(64'hFF818181818181FF, 10'd1023, 4'd15);
    send_ray(ray(0, 0, 0, 0));
    send_ray(ray(0, 0, 1024, 1024));
    send_ray(ray(511, 511, 2048, 2048));
    send_ray(ray(511, 511, 3072, 3072));
    send_ray(ray(256, 256, 0, 0));
    send_ray(ray(256, 256, 1024, 1024));
    send_ray(ray(256, 256, 2048, 2048));
    send_ray(ray(256, 256, 3072, 3072));
    send_ray(ray(256, 256, 4095, 4095));
    send_ray(ray(256, 256, 1, 0));
    send_ray(ray(256, 256, 512, 512));
    send_ray(ray(256, 256, 1536, 1536));
    send_ray(ray(200, 300, 700, 2748));
    send_ray(ray(200, 300, 700, 1724));
    send_ray(ray(100, 100, 2500, 0));
    send_ray(ray(64, 64, 2560, 2560));
    send_ray(ray(63, 63, 512, 512));
    send_ray(ray(128, 320, 3584, 3584));
    drain();
    configure(64'd0, 10'd1, 4'd1);
    send_ray(ray(256, 256, 300, 300));
    send_ray(ray(511, 0, 2048, 0));
    drain();
    configure(64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 4'd1);
    send_ray(ray(300, 100, 1000, 1000));
    send_ray(ray(0, 511, 3800, 3900));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: configure({$urandom, $urandom} & {$urandom, $urandom}, 10'd1023, 4'd15);
        1: configure({$urandom, $urandom} & {$urandom, $urandom}, 10'd1, 4'd1);
        2: configure({$urandom, $urandom}, 10'($urandom_range(1, 1023)),
                     4'($urandom_range(1, 15)));
        default: configure({$urandom, $urandom} & {$urandom, $urandom}, 10'd512, 4'd8);
      endcase
      idle_pct = ph_idle[ph];
      stall_pct = ph_stall[ph];
      for (int n = 0; n < 120; n++) begin
        // long hold-off while rays keep coming so the queue backs up
        if (ph == 0 && n == 40) hold_req = 3000;
        send_ray(random_ray());
      end
      drain();
      idle_pct = 0;
      stall_pct = 0;
    end

    if (sb.errors == 0 && sb.column_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
